>>> rtl/core/btlpm_pkg.sv
// ---------------------------------------------------------------------------
// btlpm_pkg - shared types and constants for the trie prefix-match engine
// Transaction codes, controller states and the fixed route number width.
// ---------------------------------------------------------------------------
package btlpm_pkg;

  // Route numbers are always 16 bits wide
  localparam int ROUTE_W = 16;

  // Transaction codes carried on the action port
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

>>> rtl/core/binary_trie_longest_prefix_match.sv
// ---------------------------------------------------------------------------
// binary_trie_longest_prefix_match - IPv4 longest-prefix-match engine
// Binary trie, one address bit per level, held in a single node RAM.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake        | Payload                              | Notes
//  ---------+------------------+--------------------------------------+-----------------
//  request  | start, busy      | action, address, mask, route_id      | taken: start & !busy
//  result   | done (1 cycle)   | found, matched_route, pool_full      | cannot be held off
//
//  A transaction is taken in the idle state and then walks the trie, visiting
//  1 .. ADDRESS_BITS+1 levels. The node RAM paces the walk: each level read
//  from it is one dependent registered read, and the next read address comes
//  straight from the previous read data (a freshly allocated node is not read).
//  The result strobe appears in the cycle after the last level, in which a new
//  transaction may already be taken. Reset is synchronous; it empties the trie
//  at once (node count back to one, root marked unwritten) - no clearing pass.
//
module binary_trie_longest_prefix_match
  import btlpm_pkg::*;
#(
  parameter int NODE_COUNT   = 4096,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    action,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic [ADDRESS_BITS-1:0] mask,
  input  logic [ROUTE_W-1:0]      route_id,
  output logic                    done,
  output logic                    found,
  output logic [ROUTE_W-1:0]      matched_route,
  output logic                    pool_full
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = $clog2(NODE_COUNT + 1);
  localparam int DEP_W = $clog2(ADDRESS_BITS + 1);

  // One RAM word per trie node. Child index 0 means no child (root is never a child).
  typedef struct packed {
    logic [IDX_W-1:0]   left;
    logic [IDX_W-1:0]   right;
    logic               valid;
    logic [ROUTE_W-1:0] route;
  } node_t;

  localparam int ENTRY_W = $bits(node_t);

  // Controller registers
  state_t                  state, state_next;
  logic                    op, op_next;
  logic [ADDRESS_BITS-1:0] addr_sh, addr_sh_next;   // address, current bit at MSB
  logic [ADDRESS_BITS-1:0] mask_sh, mask_sh_next;   // mask, current bit at MSB
  logic [ROUTE_W-1:0]      route, route_next;
  logic [IDX_W-1:0]        node, node_next;
  logic [DEP_W-1:0]        depth, depth_next;
  logic                    fresh, fresh_next;       // node just allocated: contents known zero
  logic                    best_hit, best_hit_next;
  logic [ROUTE_W-1:0]      best_route, best_route_next;
  logic [CNT_W-1:0]        nodes_used, nodes_used_next;
  logic                    root_init;               // root word written since reset

  // Result registers
  logic                    done_next, found_next, pool_full_next;
  logic [ROUTE_W-1:0]      matched_route_next;

  // RAM ports
  logic                    wr_en, rd_en;
  logic [IDX_W-1:0]        rd_addr;
  node_t                   wr_entry;
  logic [ENTRY_W-1:0]      ram_rd;

  // Walk datapath
  node_t                   entry;
  logic                    addr_bit, mask_bit, at_end, can_alloc;
  logic [IDX_W-1:0]        child, new_idx;
  logic                    hit_now;
  logic [ROUTE_W-1:0]      route_now;

  btlpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (node),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  assign busy = (state != ST_IDLE);

  // Current node contents. A freshly allocated node and the never-written root
  // both read as empty, so the RAM needs no clearing.
  always_comb begin
    if (fresh || (node == '0 && !root_init)) begin
      entry = '0;
    end else begin
      entry = node_t'(ram_rd);
    end
  end

  assign addr_bit  = addr_sh[ADDRESS_BITS-1];
  assign mask_bit  = mask_sh[ADDRESS_BITS-1];
  assign child     = addr_bit ? entry.right : entry.left;
  assign at_end    = (depth == DEP_W'(ADDRESS_BITS));
  assign can_alloc = (nodes_used < CNT_W'(NODE_COUNT));
  assign new_idx   = nodes_used[IDX_W-1:0];
  assign hit_now   = best_hit | entry.valid;
  assign route_now = entry.valid ? entry.route : best_route;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      nodes_used <= CNT_W'(1);
      root_init  <= 1'b0;
    end else begin
      state      <= state_next;
      done       <= done_next;
      nodes_used <= nodes_used_next;
      if (wr_en && node == '0) begin
        root_init <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op            <= op_next;
    addr_sh       <= addr_sh_next;
    mask_sh       <= mask_sh_next;
    route         <= route_next;
    node          <= node_next;
    depth         <= depth_next;
    fresh         <= fresh_next;
    best_hit      <= best_hit_next;
    best_route    <= best_route_next;
    found         <= found_next;
    matched_route <= matched_route_next;
    pool_full     <= pool_full_next;
  end

  always_comb begin
    state_next         = state;
    op_next            = op;
    addr_sh_next       = addr_sh;
    mask_sh_next       = mask_sh;
    route_next         = route;
    node_next          = node;
    depth_next         = depth;
    fresh_next         = fresh;
    best_hit_next      = best_hit;
    best_route_next    = best_route;
    nodes_used_next    = nodes_used;
    done_next          = 1'b0;
    found_next         = found;
    matched_route_next = matched_route;
    pool_full_next     = pool_full;
    rd_en              = 1'b0;
    rd_addr            = '0;
    wr_en              = 1'b0;
    wr_entry           = entry;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          // Take the transaction and fetch the root straight away
          rd_en           = 1'b1;
          rd_addr         = '0;
          state_next      = ST_WALK;
          op_next         = action;
          addr_sh_next    = address;
          mask_sh_next    = mask;
          route_next      = route_id;
          node_next       = '0;
          depth_next      = '0;
          fresh_next      = 1'b0;
          best_hit_next   = 1'b0;
          best_route_next = '0;
        end
      end

      ST_WALK: begin
        if (op == ACT_LOOKUP) begin
          best_hit_next   = hit_now;
          best_route_next = route_now;
          if (at_end || child == '0) begin
            state_next         = ST_IDLE;
            done_next          = 1'b1;
            found_next         = hit_now;
            matched_route_next = hit_now ? route_now : '0;
            pool_full_next     = 1'b0;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = child;
            node_next    = child;
            depth_next   = depth + DEP_W'(1);
            addr_sh_next = addr_sh << 1;
          end
        end else begin
          priority if (at_end || !mask_bit) begin
            // End of prefix: mark the node, unless the prefix is empty
            if (depth != '0) begin
              wr_en          = 1'b1;
              wr_entry.valid = 1'b1;
              wr_entry.route = route;
            end
            state_next         = ST_IDLE;
            done_next          = 1'b1;
            found_next         = 1'b0;
            matched_route_next = '0;
            pool_full_next     = 1'b0;
          end else if (child != '0) begin
            // Existing child: descend
            rd_en        = 1'b1;
            rd_addr      = child;
            node_next    = child;
            depth_next   = depth + DEP_W'(1);
            addr_sh_next = addr_sh << 1;
            mask_sh_next = mask_sh << 1;
          end else if (!can_alloc) begin
            // Pool exhausted; a fresh node still gets its empty word written
            wr_en              = fresh;
            state_next         = ST_IDLE;
            done_next          = 1'b1;
            found_next         = 1'b0;
            matched_route_next = '0;
            pool_full_next     = 1'b1;
          end else begin
            // Allocate child; its contents are known empty, so no read
            wr_en = 1'b1;
            if (addr_bit) begin
              wr_entry.right = new_idx;
            end else begin
              wr_entry.left = new_idx;
            end
            node_next       = new_idx;
            nodes_used_next = nodes_used + CNT_W'(1);
            fresh_next      = 1'b1;
            depth_next      = depth + DEP_W'(1);
            addr_sh_next    = addr_sh << 1;
            mask_sh_next    = mask_sh << 1;
          end
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  // Node count stays within the pool and never drops below the root
  a_pool_bounds: assert property (@(posedge clk) disable iff (rst)
    nodes_used != '0 && nodes_used <= CNT_W'(NODE_COUNT))
    else $error("node count out of range");

  // A read and a write never target the same node in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != node))
    else $error("node RAM read/write clash");

  // Result strobe only follows a walk cycle
  a_done_after_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WALK))
    else $error("result strobe without walk");

  // Pool exhaustion is only reported for inserts, which never match
  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    (done && pool_full) |-> (!found && matched_route == '0))
    else $error("pool full reported with a match");
`endif

endmodule

>>> rtl/core/btlpm_ram.sv
// ---------------------------------------------------------------------------
// btlpm_ram - generic single-clock RAM
// One write port and one read port; read data registered.
// ---------------------------------------------------------------------------
module btlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
